// ===== rtl/core/distance_history_bar_graph_assert.svh =====
// Assertion macros used by the distance history bar graph RTL.
`ifndef DISTANCE_HISTORY_BAR_GRAPH_ASSERT_SVH
`define DISTANCE_HISTORY_BAR_GRAPH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DHBG_ASSERT_SAME(label, clock, rstn, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("dhbg assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DHBG_ASSERT_NEXT(label, clock, rstn, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("dhbg assertion failed");

`endif

// ===== rtl/core/dhbg_pkg.sv =====
// ----------------------------------------------------------------------------
// dhbg_pkg
// Shared constants, types and functions of the distance history bar graph.
// ----------------------------------------------------------------------------
package dhbg_pkg;

	localparam int HISTORY_DEPTH   = 8;
	localparam int DISPLAY_COLUMNS = 8;
	localparam int NUM_COLS        = (HISTORY_DEPTH < DISPLAY_COLUMNS) ?
		HISTORY_DEPTH : DISPLAY_COLUMNS;
	localparam int PTR_W           = $clog2(HISTORY_DEPTH);
	localparam int COL_W           = $clog2(NUM_COLS);

	localparam int DIST_W   = 9;
	localparam int HEIGHT_W = 4;
	localparam int COLUMN_W = 3;
	localparam int MASK_W   = 8;

	localparam logic [DIST_W-1:0] MAX_DISTANCE = DIST_W'(400);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [HEIGHT_W-1:0] height;
	} dhbg_item_t;

	typedef enum logic {
		BACK_IDLE,
		BACK_RUN
	} back_state_t;

	function automatic logic [HEIGHT_W-1:0] height_of(input logic [DIST_W-1:0] d);
		logic [HEIGHT_W-1:0] h;
		if (d == '0)                 h = HEIGHT_W'(0);
		else if (d <= DIST_W'(5))    h = HEIGHT_W'(8);
		else if (d <= DIST_W'(10))   h = HEIGHT_W'(7);
		else if (d <= DIST_W'(20))   h = HEIGHT_W'(6);
		else if (d <= DIST_W'(30))   h = HEIGHT_W'(5);
		else if (d <= DIST_W'(50))   h = HEIGHT_W'(4);
		else if (d <= DIST_W'(70))   h = HEIGHT_W'(3);
		else if (d <= DIST_W'(110))  h = HEIGHT_W'(2);
		else                         h = HEIGHT_W'(1);
		return h;
	endfunction

	function automatic logic [MASK_W-1:0] mask_of(input logic [HEIGHT_W-1:0] h);
		logic [MASK_W-1:0] m;
		for (int i = 0; i < MASK_W; i++) begin
			m[i] = (HEIGHT_W'(i) < h);
		end
		return m;
	endfunction

endpackage

// ===== rtl/core/dhbg_ram.sv =====
// ----------------------------------------------------------------------------
// dhbg_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dhbg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/dhbg_front.sv =====
// ----------------------------------------------------------------------------
// dhbg_front
// Accepts samples, saturates them and classifies each into a bar height.
// ----------------------------------------------------------------------------
module dhbg_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [dhbg_pkg::DIST_W-1:0]  sample_distance,
	output logic                         item_valid,
	input  logic                         item_ready,
	output dhbg_pkg::dhbg_item_t         item
);
	import dhbg_pkg::*;

	logic                valid_s1;
	dhbg_item_t          item_s1;
	logic [DIST_W-1:0]   sat_dist;

	assign sat_dist = (sample_distance > MAX_DISTANCE) ? MAX_DISTANCE : sample_distance;
	assign in_ready = !valid_s1 || item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.height <= height_of(sat_dist);
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

// ===== rtl/core/dhbg_queue.sv =====
// ----------------------------------------------------------------------------
// dhbg_queue
// Short FIFO of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module dhbg_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  dhbg_pkg::dhbg_item_t push_item,
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output dhbg_pkg::dhbg_item_t pop_item
);
	import dhbg_pkg::*;

	dhbg_item_t          slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     count_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = (count_q != (QPTR_W+1)'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_item   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== rtl/core/dhbg_back.sv =====
// ----------------------------------------------------------------------------
// dhbg_back
// Writes each height into the ring history and streams out the columns,
// newest first, one RAM read per column.
// ----------------------------------------------------------------------------
`include "distance_history_bar_graph_assert.svh"

module dhbg_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  dhbg_pkg::dhbg_item_t           req_item,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [dhbg_pkg::COLUMN_W-1:0]  column_index,
	output logic [dhbg_pkg::HEIGHT_W-1:0]  bar_height,
	output logic [dhbg_pkg::MASK_W-1:0]    column_mask,
	output logic                           last_column
);
	import dhbg_pkg::*;

	back_state_t              state_q;
	back_state_t              state_d;
	logic [PTR_W-1:0]         wr_ptr_q;
	logic [PTR_W-1:0]         pos_q;
	logic [COL_W-1:0]         col_q;
	logic [HISTORY_DEPTH-1:0] filled_q;
	logic                     out_valid_q;
	logic [COL_W-1:0]         col_out_q;
	logic                     last_q;
	logic                     filled_rd_q;
	logic [HEIGHT_W-1:0]      rd_height;
	logic                     load;
	logic                     issue;
	logic                     col_last;

	assign col_last = (col_q == COL_W'(NUM_COLS-1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			BACK_IDLE: if (req_valid) state_d = BACK_RUN;
			BACK_RUN:  if (issue && col_last) state_d = BACK_IDLE;
			default:   state_d = BACK_IDLE;
		endcase
	end

	always_comb begin
		load  = 1'b0;
		issue = 1'b0;
		case (state_q)
			BACK_IDLE: load  = req_valid;
			BACK_RUN:  issue = !out_valid_q || out_ready;
			default: begin
				load  = 1'b0;
				issue = 1'b0;
			end
		endcase
	end

	assign req_ready = load;

	dhbg_ram #(
		.WIDTH(HEIGHT_W),
		.DEPTH(HISTORY_DEPTH)
	) u_history (
		.clk  (clk),
		.we   (load),
		.waddr(wr_ptr_q),
		.wdata(req_item.height),
		.re   (issue),
		.raddr(pos_q),
		.rdata(rd_height)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BACK_IDLE;
			wr_ptr_q    <= '0;
			pos_q       <= '0;
			col_q       <= '0;
			filled_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				filled_q[wr_ptr_q] <= 1'b1;
				pos_q    <= wr_ptr_q;
				col_q    <= '0;
				wr_ptr_q <= (wr_ptr_q == PTR_W'(HISTORY_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (issue) begin
				// Walk backward from the newest entry, wrapping below slot zero.
				pos_q <= (pos_q == '0) ? PTR_W'(HISTORY_DEPTH-1) : pos_q - 1'b1;
				col_q <= col_q + 1'b1;
			end
			if (issue) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			col_out_q   <= col_q;
			last_q      <= col_last;
			filled_rd_q <= filled_q[pos_q];
		end
	end

	// An entry never written reads as a zero distance, which gives no bar.
	assign out_valid    = out_valid_q;
	assign column_index = COLUMN_W'(col_out_q);
	assign bar_height   = filled_rd_q ? rd_height : '0;
	assign column_mask  = mask_of(bar_height);
	assign last_column  = last_q;

	`DHBG_ASSERT_SAME(a_load_only_idle, clk, arst_n, load, state_q == BACK_IDLE && !issue)
	`DHBG_ASSERT_NEXT(a_load_starts_run, clk, arst_n, load,
		state_q == BACK_RUN && col_q == '0 && filled_q[pos_q])
	`DHBG_ASSERT_NEXT(a_issue_shows, clk, arst_n, issue, out_valid_q)
	`DHBG_ASSERT_SAME(a_last_matches, clk, arst_n, out_valid_q && last_q,
		col_out_q == COL_W'(NUM_COLS-1))

endmodule

// ===== rtl/core/distance_history_bar_graph.sv =====
// A sample passes the front register and the request queue; the back end then writes it into
// the history RAM and reads its 8 columns, one read per column, all through the single read
// port, holding while the output is not ready, and loads no new sample until the last issue.
// A 2-entry request queue lets up to three samples be taken while the back end is busy.
// Reset (arst_n low, asynchronous) empties the pipeline and queue, zeroes the write
// pointer and marks every history entry unwritten, so it reads as a zero distance.
// ----------------------------------------------------------------------------
// distance_history_bar_graph
// Ring history of distance samples shown as eight thermometer bar columns.
// ----------------------------------------------------------------------------
module distance_history_bar_graph (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [dhbg_pkg::DIST_W-1:0]    sample_distance,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [dhbg_pkg::COLUMN_W-1:0]  column_index,
	output logic [dhbg_pkg::HEIGHT_W-1:0]  bar_height,
	output logic [dhbg_pkg::MASK_W-1:0]    column_mask,
	output logic                           last_column
);
	import dhbg_pkg::*;

	logic       front_valid;
	logic       front_ready;
	dhbg_item_t front_item;
	logic       req_valid;
	logic       req_ready;
	dhbg_item_t req_item;

	dhbg_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.sample_distance(sample_distance),
		.item_valid     (front_valid),
		.item_ready     (front_ready),
		.item           (front_item)
	);

	dhbg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(front_valid),
		.push_ready(front_ready),
		.push_item (front_item),
		.pop_valid (req_valid),
		.pop_ready (req_ready),
		.pop_item  (req_item)
	);

	dhbg_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req_item    (req_item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.column_index(column_index),
		.bar_height  (bar_height),
		.column_mask (column_mask),
		.last_column (last_column)
	);

endmodule

// ===== tb/sv/distance_history_bar_graph_checker.sv =====
// ----------------------------------------------------------------------------
// distance_history_bar_graph_checker
// Watches both request channels of the bar graph block, keeps its own copy of
// the distance history, predicts the columns of every sample and compares
// each column that leaves the block with the oldest prediction.
// ----------------------------------------------------------------------------
module distance_history_bar_graph_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic [dhbg_pkg::DIST_W-1:0]    sample_distance,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [dhbg_pkg::COLUMN_W-1:0]  column_index,
	input  logic [dhbg_pkg::HEIGHT_W-1:0]  bar_height,
	input  logic [dhbg_pkg::MASK_W-1:0]    column_mask,
	input  logic                           last_column,
	output int                             fail_count,
	output int                             pending_columns,
	output int                             columns_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RING_DEPTH  = dhbg_pkg::HISTORY_DEPTH;
	localparam int SHOWN_COLS  = (RING_DEPTH < 8) ? RING_DEPTH : 8;
	localparam int DIST_CAP    = 400;

	typedef struct {
		logic [dhbg_pkg::COLUMN_W-1:0] column;
		logic [dhbg_pkg::HEIGHT_W-1:0] height;
		logic [dhbg_pkg::MASK_W-1:0]   mask;
		logic                          last;
	} column_expect_t;

	column_expect_t             expected_columns[$];
	logic [dhbg_pkg::DIST_W-1:0] distance_ring[RING_DEPTH];
	int                         ring_wr_ptr;

	initial begin
		fail_count      = 0;
		pending_columns = 0;
		columns_checked = 0;
	end

	function automatic logic [dhbg_pkg::HEIGHT_W-1:0] bar_height_for(
		input logic [dhbg_pkg::DIST_W-1:0] dist_cm);
		if (dist_cm == 0)        return 4'd0;
		else if (dist_cm <= 5)   return 4'd8;
		else if (dist_cm <= 10)  return 4'd7;
		else if (dist_cm <= 20)  return 4'd6;
		else if (dist_cm <= 30)  return 4'd5;
		else if (dist_cm <= 50)  return 4'd4;
		else if (dist_cm <= 70)  return 4'd3;
		else if (dist_cm <= 110) return 4'd2;
		else                     return 4'd1;
	endfunction

	// Stores the saturated sample and queues the columns it brings out,
	// newest entry first, walking backwards around the ring.
	task automatic record_sample(input logic [dhbg_pkg::DIST_W-1:0] raw);
		logic [dhbg_pkg::DIST_W-1:0] capped;
		int                          pos;
		column_expect_t              col;
		capped = (raw > DIST_CAP) ? dhbg_pkg::DIST_W'(DIST_CAP) : raw;
		distance_ring[ring_wr_ptr] = capped;
		pos = ring_wr_ptr;
		ring_wr_ptr = (ring_wr_ptr + 1 >= RING_DEPTH) ? 0 : ring_wr_ptr + 1;
		for (int k = 0; k < SHOWN_COLS; k++) begin
			col.column = dhbg_pkg::COLUMN_W'(k);
			col.height = bar_height_for(distance_ring[pos]);
			col.mask   = dhbg_pkg::MASK_W'((16'd1 << col.height) - 16'd1);
			col.last   = (k + 1 == SHOWN_COLS);
			expected_columns.push_back(col);
			pos = (pos == 0) ? RING_DEPTH - 1 : pos - 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		column_expect_t want;
		if (!arst_n) begin
			for (int i = 0; i < RING_DEPTH; i++) distance_ring[i] = '0;
			ring_wr_ptr = 0;
			expected_columns.delete();
		end else begin
			// The column is checked before a sample taken in the same cycle is
			// queued, so a stray column can never match a fresh prediction.
			if (out_valid && out_ready) begin
				if (expected_columns.size() == 0) begin
					$error("column request with no prediction pending: column_index %0d",
						column_index);
					fail_count++;
				end else begin
					want = expected_columns.pop_front();
					columns_checked++;
					if (column_index !== want.column) begin
						$error("column_index: expected %0d, actual %0d", want.column,
							column_index);
						fail_count++;
					end
					if (bar_height !== want.height) begin
						$error("bar_height: expected %0d, actual %0d", want.height,
							bar_height);
						fail_count++;
					end
					if (column_mask !== want.mask) begin
						$error("column_mask: expected 0x%02h, actual 0x%02h", want.mask,
							column_mask);
						fail_count++;
					end
					if (last_column !== want.last) begin
						$error("last_column: expected %0d, actual %0d", want.last,
							last_column);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) record_sample(sample_distance);
		end
		pending_columns = expected_columns.size();
	end

endmodule

// ===== tb/sv/tb_distance_history_bar_graph.sv =====
// ----------------------------------------------------------------------------
// tb_distance_history_bar_graph
// Drives distance samples into the bar graph block: a directed pass over the
// ladder thresholds, saturation and the unfilled history, then random
// samples under three backpressure phases. A checker beside the block does
// the prediction; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_distance_history_bar_graph;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_SAMPLES = 100;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 20;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic [dhbg_pkg::DIST_W-1:0]    sample_distance = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [dhbg_pkg::COLUMN_W-1:0]  column_index;
	logic [dhbg_pkg::HEIGHT_W-1:0]  bar_height;
	logic [dhbg_pkg::MASK_W-1:0]    column_mask;
	logic                           last_column;

	int fail_count;
	int pending_columns;
	int columns_checked;
	int send_idle_pct = 19;
	int recv_idle_pct = 49;
	int samples_sent  = 0;
	int stall_cycles  = 0;

	distance_history_bar_graph dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.sample_distance (sample_distance),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.column_index    (column_index),
		.bar_height      (bar_height),
		.column_mask     (column_mask),
		.last_column     (last_column)
	);

	distance_history_bar_graph_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.sample_distance (sample_distance),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.column_index    (column_index),
		.bar_height      (bar_height),
		.column_mask     (column_mask),
		.last_column     (last_column),
		.fail_count      (fail_count),
		.pending_columns (pending_columns),
		.columns_checked (columns_checked)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_ready = ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Called at a falling edge and returns at one; valid stays high when the
	// next sample follows without a gap.
	task automatic send_sample(input logic [dhbg_pkg::DIST_W-1:0] dist_cm);
		logic taken;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid        = 1'b1;
		sample_distance = dist_cm;
		taken           = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = in_ready;
			@(negedge clk);
		end
		samples_sent++;
	endtask

	// Mostly values near the ladder thresholds and the saturation point.
	function automatic logic [dhbg_pkg::DIST_W-1:0] pick_distance();
		int edges[9] = '{0, 5, 10, 20, 30, 50, 70, 110, 400};
		int v;
		case ($urandom_range(3))
			0: v = $urandom_range(511);
			1: v = $urandom_range(120);
			2: v = edges[$urandom_range(8)] + $urandom_range(2) - 1;
			default: v = $urandom_range(511, 380);
		endcase
		if (v < 0) v = 0;
		return dhbg_pkg::DIST_W'(v);
	endfunction

	initial begin
		int directed[22] = '{3, 0, 1, 5, 6, 10, 11, 20, 21, 30, 31, 50, 51, 70, 71,
			110, 111, 399, 400, 401, 511, 256};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// The first sample lands in an empty history, so its older columns are blank.
		foreach (directed[i]) send_sample(dhbg_pkg::DIST_W'(directed[i]));

		for (int n = 0; n < RANDOM_SAMPLES; n++) begin
			if (n == RANDOM_SAMPLES / 3) begin
				send_idle_pct = 49;
				recv_idle_pct = 19;
			end else if (n == 2 * RANDOM_SAMPLES / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			send_sample(pick_distance());
		end
		in_valid = 1'b0;

		while (pending_columns != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (pending_columns != 0) begin
			$error("%0d predicted columns never came out", pending_columns);
		end

		$display("covered %0d samples (ladder edges, saturation, ring wrap) and %0d columns",
			samples_sent, columns_checked);
		$display("backpressure phases: sender-heavy, receiver-heavy, none");
		if (fail_count == 0 && pending_columns == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/dhbg_pkg.sv
rtl/core/dhbg_ram.sv
rtl/core/dhbg_front.sv
rtl/core/dhbg_queue.sv
rtl/core/dhbg_back.sv
rtl/core/distance_history_bar_graph.sv
tb/sv/distance_history_bar_graph_checker.sv
tb/sv/tb_distance_history_bar_graph.sv
